// File: rtl/faoac_pkg.sv
// ----------------------------------------------------------------------------
// faoac_pkg
// Types, register codes, reset values and helpers shared by the alert
// controller.
// ----------------------------------------------------------------------------
`default_nettype none

package faoac_pkg;

    // distance in cm = (echo_us * 1124) >> 16, saturated to 400
    localparam logic [10:0] DIST_SCALE = 11'd1124;
    localparam int          DIST_SHIFT = 16;
    localparam logic [8:0]  DIST_MAX   = 9'd400;

    localparam int CFG_ADDR_W = 3;
    localparam int CFG_DATA_W = 32;

    typedef enum logic [CFG_ADDR_W-1:0] {
        CFG_FALL_THRESHOLD_SQ = 3'd0,
        CFG_ECHO_MIN_US       = 3'd1,
        CFG_ECHO_MAX_US       = 3'd2,
        CFG_OBSTACLE_MAX_US   = 3'd3,
        CFG_FALL_VIBE_MS      = 3'd4,
        CFG_TONE_REPEAT_MS    = 3'd5,
        CFG_PULSE_PERIOD_MS   = 3'd6,
        CFG_REFRESH_MS        = 3'd7
    } t_cfg_idx;

    typedef struct packed {
        logic [31:0] fall_threshold_sq;
        logic [15:0] echo_min_us;
        logic [15:0] echo_max_us;
        logic [15:0] obstacle_max_us;
        logic [15:0] fall_vibe_ms;
        logic [15:0] tone_repeat_ms;
        logic [15:0] pulse_period_ms;
        logic [15:0] refresh_ms;
    } t_cfg;

    localparam t_cfg CFG_RESET = '{
        fall_threshold_sq: 32'd7088374,
        echo_min_us:       16'd117,
        echo_max_us:       16'd23323,
        obstacle_max_us:   16'd4664,
        fall_vibe_ms:      16'd1500,
        tone_repeat_ms:    16'd1200,
        pulse_period_ms:   16'd300,
        refresh_ms:        16'd500
    };

    typedef struct packed {
        logic [31:0]        now_ms;
        logic               accel_valid;
        logic signed [15:0] accel_x;
        logic signed [15:0] accel_y;
        logic signed [15:0] accel_z;
        logic               echo_valid;
        logic [15:0]        echo_us;
    } t_item;

    typedef struct packed {
        logic       monitor_refresh;
        logic       path_clear;
        logic       obstacle_repeat;
        logic       obstacle_alarm;
        logic       recovered;
        logic       fall_alarm;
        logic [8:0] distance_cm;
        logic       obstacle_flag;
        logic       fall_flag;
        logic       motor_on;
    } t_result;

    // square of a raw signed sample; -32768 squares to 2^30
    function automatic logic [31:0] sq16(input logic signed [15:0] x);
        logic [15:0] u;
        logic [15:0] mag;
        u   = x;
        mag = u[15] ? (16'(~u) + 16'd1) : u;
        return 32'({16'b0, mag} * {16'b0, mag});
    endfunction

endpackage

`default_nettype wire

// File: rtl/fall_and_obstacle_alert_controller.sv
// Pipeline: input register, then result register, which drives o_m_tvalid.
// Throughput: one transaction per cycle unless the master side stalls; the pass
//   logic updates its state as an item moves from the input register to the
//   result register.
// Reset: synchronous, active low; clears state, valids and loads register
//   reset values.
// ----------------------------------------------------------------------------
// fall_and_obstacle_alert_controller
// Fall and obstacle alert controller: one monitoring pass per stream
// transaction, one result transaction per pass.
// ----------------------------------------------------------------------------
`default_nettype none

module fall_and_obstacle_alert_controller
    import faoac_pkg::*;
(
    input  wire logic                  i_clk,
    input  wire logic                  i_rst_n,
    // configuration write port
    input  wire logic                  i_cfg_we,
    input  wire logic [CFG_ADDR_W-1:0] i_cfg_addr,
    input  wire logic [CFG_DATA_W-1:0] i_cfg_wdata,
    // slave side
    input  wire logic                  i_s_tvalid,
    output logic                       o_s_tready,
    // now_ms[31:0], accel_x[47:32], accel_y[63:48], accel_z[79:64], echo_us[95:80]
    input  wire logic [95:0]           i_s_tdata,
    // accel_valid[0], echo_valid[1]
    input  wire logic [1:0]            i_s_tuser,
    // master side
    output logic                       o_m_tvalid,
    input  wire logic                  i_m_tready,
    // motor_on[0], fall_flag[1], obstacle_flag[2], distance_cm[11:3], fall_alarm[12],
    // recovered[13], obstacle_alarm[14], obstacle_repeat[15], path_clear[16],
    // monitor_refresh[17], zero[23:18]
    output logic [23:0]                o_m_tdata
);

    t_cfg    r_cfg;
    logic    r_in_valid;
    t_item   r_in_item;
    logic    r_out_valid;
    t_result r_out;
    t_result w_result;
    t_item   w_item;
    logic    w_out_free;
    logic    w_fire;
    logic    w_accept;

    assign w_item = '{
        now_ms:      i_s_tdata[31:0],
        accel_valid: i_s_tuser[0],
        accel_x:     i_s_tdata[47:32],
        accel_y:     i_s_tdata[63:48],
        accel_z:     i_s_tdata[79:64],
        echo_valid:  i_s_tuser[1],
        echo_us:     i_s_tdata[95:80]
    };

    assign w_out_free = !r_out_valid || i_m_tready;
    assign w_fire     = r_in_valid && w_out_free;
    assign o_s_tready = !r_in_valid || w_out_free;
    assign w_accept   = i_s_tvalid && o_s_tready;

    assign o_m_tvalid = r_out_valid;
    assign o_m_tdata  = {6'b0, r_out};

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg <= CFG_RESET;
        end else if (i_cfg_we) begin
            unique case (t_cfg_idx'(i_cfg_addr))
                CFG_FALL_THRESHOLD_SQ: r_cfg.fall_threshold_sq <= i_cfg_wdata;
                CFG_ECHO_MIN_US:       r_cfg.echo_min_us       <= i_cfg_wdata[15:0];
                CFG_ECHO_MAX_US:       r_cfg.echo_max_us       <= i_cfg_wdata[15:0];
                CFG_OBSTACLE_MAX_US:   r_cfg.obstacle_max_us   <= i_cfg_wdata[15:0];
                CFG_FALL_VIBE_MS:      r_cfg.fall_vibe_ms      <= i_cfg_wdata[15:0];
                CFG_TONE_REPEAT_MS:    r_cfg.tone_repeat_ms    <= i_cfg_wdata[15:0];
                CFG_PULSE_PERIOD_MS:   r_cfg.pulse_period_ms   <= i_cfg_wdata[15:0];
                CFG_REFRESH_MS:        r_cfg.refresh_ms        <= i_cfg_wdata[15:0];
            endcase
        end
    end

    // input register: refill as the held transaction moves on
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid <= 1'b0;
        end else if (w_accept) begin
            r_in_valid <= 1'b1;
        end else if (w_fire) begin
            r_in_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_accept) begin
            r_in_item <= w_item;
        end
    end

    faoac_pass u_pass (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_fire   (w_fire),
        .i_item   (r_in_item),
        .i_cfg    (r_cfg),
        .o_result (w_result)
    );

    // result register: hold while the master side stalls
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (w_fire) begin
            r_out_valid <= 1'b1;
        end else if (i_m_tready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_fire) begin
            r_out <= w_result;
        end
    end

endmodule

`default_nettype wire

// File: rtl/faoac_pass.sv
// ----------------------------------------------------------------------------
// faoac_pass
// Alert state and one monitoring pass: free fall test, echo range and
// distance, edge events, timers and vibration drive.
// ----------------------------------------------------------------------------
`default_nettype none

module faoac_pass
    import faoac_pkg::*;
(
    input  wire logic    i_clk,
    input  wire logic    i_rst_n,
    input  wire logic    i_fire,
    input  wire t_item   i_item,
    input  wire t_cfg    i_cfg,
    output t_result      o_result
);

    logic        r_fall,        n_fall;
    logic        r_obs,         n_obs;
    logic [8:0]  r_dist,        n_dist;
    logic [31:0] r_vibe_end,    n_vibe_end;
    logic [31:0] r_last_tone,   n_last_tone;
    logic [31:0] r_last_toggle, n_last_toggle;
    logic [31:0] r_last_refresh, n_last_refresh;
    logic        r_phase,       n_phase;
    logic        r_motor,       n_motor;

    logic [31:0] w_sum;
    logic [26:0] w_prod;
    logic [10:0] w_dist_raw;
    logic        w_in_window;
    logic [31:0] w_now;

    assign w_now      = i_item.now_ms;
    assign w_sum      = sq16(i_item.accel_x) + sq16(i_item.accel_y) + sq16(i_item.accel_z);
    assign w_prod     = 27'(i_item.echo_us) * 27'(DIST_SCALE);
    assign w_dist_raw = w_prod[26:DIST_SHIFT];
    assign w_in_window = (i_item.echo_us >= i_cfg.echo_min_us) &&
                         (i_item.echo_us <= i_cfg.echo_max_us);

    always_comb begin
        n_fall         = r_fall;
        n_obs          = r_obs;
        n_dist         = r_dist;
        n_vibe_end     = r_vibe_end;
        n_last_tone    = r_last_tone;
        n_last_toggle  = r_last_toggle;
        n_last_refresh = r_last_refresh;
        n_phase        = r_phase;
        n_motor        = r_motor;
        o_result       = '0;

        if (i_item.accel_valid) begin
            n_fall = w_sum < i_cfg.fall_threshold_sq;
        end

        if (i_item.echo_valid) begin
            if (w_in_window) begin
                n_dist = (w_dist_raw > 11'(DIST_MAX)) ? DIST_MAX : w_dist_raw[8:0];
                n_obs  = i_item.echo_us <= i_cfg.obstacle_max_us;
            end else begin
                n_dist = '0;
                n_obs  = 1'b0;
            end
        end

        if (n_fall && !r_fall) begin
            o_result.fall_alarm = 1'b1;
            n_vibe_end          = w_now + 32'(i_cfg.fall_vibe_ms);
        end else if (!n_fall && r_fall) begin
            o_result.recovered = 1'b1;
        end

        if (n_obs) begin
            if (!r_obs) begin
                o_result.obstacle_alarm = 1'b1;
                n_last_tone             = w_now;
            end else if ((w_now - r_last_tone) >= 32'(i_cfg.tone_repeat_ms)) begin
                o_result.obstacle_repeat = 1'b1;
                n_last_tone              = w_now;
            end
        end else if (r_obs) begin
            o_result.path_clear = 1'b1;
        end

        if (!n_obs && !n_fall && ((w_now - r_last_refresh) >= 32'(i_cfg.refresh_ms))) begin
            o_result.monitor_refresh = 1'b1;
            n_last_refresh           = w_now;
        end

        // steady drive wins over obstacle pulsing; plain unsigned compare
        if (w_now < n_vibe_end) begin
            n_motor = 1'b1;
        end else if (n_obs) begin
            if ((w_now - r_last_toggle) >= 32'(i_cfg.pulse_period_ms)) begin
                n_last_toggle = w_now;
                n_phase       = !r_phase;
                n_motor       = !r_phase;
            end
        end else begin
            n_motor = 1'b0;
            n_phase = 1'b0;
        end

        o_result.motor_on      = n_motor;
        o_result.fall_flag     = n_fall;
        o_result.obstacle_flag = n_obs;
        o_result.distance_cm   = n_dist;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_fall         <= 1'b0;
            r_obs          <= 1'b0;
            r_dist         <= '0;
            r_vibe_end     <= '0;
            r_last_tone    <= '0;
            r_last_toggle  <= '0;
            r_last_refresh <= '0;
            r_phase        <= 1'b0;
            r_motor        <= 1'b0;
        end else if (i_fire) begin
            r_fall         <= n_fall;
            r_obs          <= n_obs;
            r_dist         <= n_dist;
            r_vibe_end     <= n_vibe_end;
            r_last_tone    <= n_last_tone;
            r_last_toggle  <= n_last_toggle;
            r_last_refresh <= n_last_refresh;
            r_phase        <= n_phase;
            r_motor        <= n_motor;
        end
    end

endmodule

`default_nettype wire

// File: rtl/faoac_checker.sv
// ----------------------------------------------------------------------------
// faoac_checker
// Port-level checks on result transactions of the alert controller.
// ----------------------------------------------------------------------------
`default_nettype none

module faoac_checker (
    input wire logic        i_clk,
    input wire logic        i_rst_n,
    input wire logic        o_m_tvalid,
    input wire logic        i_m_tready,
    input wire logic [23:0] o_m_tdata
);

    // fall edge events agree with the fall flag
    a_fall_edges: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_m_tvalid |-> (!o_m_tdata[12] || o_m_tdata[1]) && (!o_m_tdata[13] || !o_m_tdata[1]))
        else $error("fall event disagrees with fall flag");

    // obstacle events agree with the obstacle flag
    a_obs_edges: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_m_tvalid |-> (!(o_m_tdata[14] || o_m_tdata[15]) || o_m_tdata[2]) &&
                       (!o_m_tdata[16] || !o_m_tdata[2]) && !(o_m_tdata[14] && o_m_tdata[15]))
        else $error("obstacle event disagrees with obstacle flag");

    // refresh only while neither alert is held
    a_refresh_idle: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_m_tvalid && o_m_tdata[17]) |-> (!o_m_tdata[1] && !o_m_tdata[2]))
        else $error("refresh during an alert");

    // distance saturates at 400 cm
    a_dist_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_m_tvalid |-> (o_m_tdata[11:3] <= 9'd400))
        else $error("distance out of range");

    a_hold_stall: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_m_tvalid && !i_m_tready) |=> (o_m_tvalid && $stable(o_m_tdata)))
        else $error("result changed while stalled");

endmodule

bind fall_and_obstacle_alert_controller faoac_checker u_faoac_checker (
    .i_clk      (i_clk),
    .i_rst_n    (i_rst_n),
    .o_m_tvalid (o_m_tvalid),
    .i_m_tready (i_m_tready),
    .o_m_tdata  (o_m_tdata)
);

`default_nettype wire
